// ===== rtl/core/ppo_pkg.sv =====
// Package for the percentage price oscillator: widths, register indexes,
// shared status structs. No dependencies.
`default_nettype none
package ppo_pkg;
  localparam int unsigned PriceW = 32;
  localparam int unsigned SumW   = 42;
  localparam int unsigned PerW   = 11;
  localparam int unsigned WgtW   = 16;

  typedef enum logic [2:0] {
    REG_SHORT_PERIOD  = 3'd0,
    REG_LONG_PERIOD   = 3'd1,
    REG_SIGNAL_PERIOD = 3'd2,
    REG_DIVIDE_LONG   = 3'd3,
    REG_SHORT_WEIGHT  = 3'd4,
    REG_LONG_WEIGHT   = 3'd5,
    REG_SIGNAL_WEIGHT = 3'd6,
    REG_NONE          = 3'd7
  } reg_idx_e;

  // request/response between sequencer and shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/ppo_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ppo_pkg.
`default_nettype none
module ppo_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ppo_pkg::div_req_t req_i,
  output ppo_pkg::div_rsp_t      rsp_o
);
  logic [63:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dsr_q, dsr_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dsr_d = dsr_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q[31:0], quo_q[63]};
    trial = {1'b0, shifted} - {2'b00, dsr_q};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; dsr_d = req_i.divisor;
      cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract where it fits
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

// ===== rtl/core/percentage_price_oscillator.sv =====
// Top level of the percentage price oscillator: sequencer, state, config.
// Depends on ppo_pkg and ppo_div.
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// in       | to block  | in_valid/in_stall  | price_i, series_start_i
// out      | from      | out_valid/out_stall| osc_value_o .. signal_ready_o
// cfg      | to block  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// Each item passes S_SHORT, S_LONG and S_PPO; once PPO is formed it also passes
// the shared 64-step divider for the PPO ratio and S_SIG, and S_BLEND when the
// signal line is blended. The divider runs up to four times for one item (short
// seed, long seed, PPO ratio, signal seed). Reset clears configuration to its
// defaults and all series state. The result waits in the output register; an
// output stall holds it there, and a new item is taken from the cycle after the
// result has gone.
module percentage_price_oscillator #(
  parameter int unsigned PERIOD_LIMIT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] price_i,
  input  wire logic        series_start_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      osc_value_o,
  output logic             ppo_ready_o,
  output logic [31:0]      signal_value_o,
  output logic [31:0]      histogram_value_o,
  output logic             signal_ready_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam logic [10:0] MaxP = 11'(PERIOD_LIMIT > 2047 ? 2047 : PERIOD_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE, S_SHORT, S_SDIV, S_LONG, S_LDIV, S_PPO, S_PDIV, S_SIG, S_GDIV,
    S_BLEND, S_OUT
  } state_e;

  state_e state_q;
  logic [10:0] sp_cfg_q, lp_cfg_q, gp_cfg_q;
  logic        dbl_q;
  logic [15:0] sw_q, lw_q, gw_q;
  logic [10:0] seen_q, cnt_q;
  logic [41:0] ssum_q, lsum_q;
  logic signed [41:0] psum_q;
  logic [31:0] savg_q, lavg_q, gavg_q, price_q, ppo_q;
  logic        ppo_ok_q, sig_ok_q, neg_q;
  logic [10:0] prev_q;
  logic [31:0] hist_q;

  ppo_pkg::div_req_t req;
  ppo_pkg::div_rsp_t rsp;
  ppo_div u_div (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  function automatic logic [10:0] eff(input logic [10:0] p);
    logic [10:0] r;
    r = p;
    if (p == '0) r = 11'd1;
    else if (p > MaxP) r = MaxP;
    return r;
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] x,
                                        input logic [15:0] w);
    logic [49:0] acc;
    acc = 50'(a) * 50'(17'h10000 - 17'(w)) + 50'(x) * 50'(w) + 50'd32768;
    return acc[47:16];
  endfunction

  function automatic logic [31:0] sat(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) r = 32'h7fffffff;
    else if (v < -43'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic [10:0] sp, lp, gp, cap;
  assign sp = eff(sp_cfg_q);
  assign lp = eff(lp_cfg_q);
  assign gp = eff(gp_cfg_q);
  assign cap = (sp > lp) ? sp : lp;

  logic [31:0] den, mag;
  logic [41:0] pmag;
  logic signed [41:0] psum_nx;
  logic [63:0] q64;
  logic [32:0] qc;
  logic signed [42:0] ppo_s;
  assign den  = dbl_q ? lavg_q : savg_q;
  assign mag  = (savg_q < lavg_q) ? lavg_q - savg_q : savg_q - lavg_q;
  // running PPO sum including the value of this item
  assign psum_nx = psum_q + 42'(signed'(ppo_q));
  assign pmag = psum_nx[41] ? 42'(-psum_nx) : 42'(psum_nx);
  assign q64  = rsp.quotient;
  assign qc   = (q64 > 64'h1_0000_0000) ? 33'h1_0000_0000 : q64[32:0];
  assign ppo_s = neg_q ? -43'(qc) : 43'(qc);

  always_comb begin
    req = '0;
    case (state_q)
      S_SHORT: begin
        req.dividend = 64'(ssum_q + 42'(price_q)); req.divisor = 32'(sp);
      end
      S_LONG: begin
        req.dividend = 64'(lsum_q + 42'(price_q)); req.divisor = 32'(lp);
      end
      S_PPO:   begin req.dividend = 64'(mag) * 64'd6553600; req.divisor = den; end
      S_SIG:   begin req.dividend = 64'(pmag); req.divisor = 32'(gp); end
      default: ;
    endcase
    req.start = (state_q == S_SHORT && prev_q < sp && prev_q + 11'd1 == sp)
             || (state_q == S_LONG && prev_q < lp && prev_q + 11'd1 == lp)
             || (state_q == S_PPO && prev_q + 11'd1 >= cap && den != '0)
             || (state_q == S_SIG && ppo_ok_q && cnt_q + 11'd1 == gp && cnt_q < gp);
  end

  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = (state_q == S_OUT);
  assign osc_value_o = ppo_q;
  assign ppo_ready_o = ppo_ok_q;
  assign signal_value_o = gavg_q & {32{sig_ok_q}};
  assign histogram_value_o = hist_q;
  assign signal_ready_o = sig_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_cfg_q <= 11'd12; lp_cfg_q <= 11'd26; gp_cfg_q <= 11'd9; dbl_q <= 1'b1;
      sw_q <= 16'd10082; lw_q <= 16'd4855; gw_q <= 16'd13107;
      seen_q <= '0; cnt_q <= '0; ssum_q <= '0; lsum_q <= '0; psum_q <= '0;
      savg_q <= '0; lavg_q <= '0; gavg_q <= '0;
      price_q <= '0; ppo_q <= '0; ppo_ok_q <= 1'b0; sig_ok_q <= 1'b0;
      neg_q <= 1'b0; prev_q <= '0; hist_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (ppo_pkg::reg_idx_e'(cfg_idx_i))
          ppo_pkg::REG_SHORT_PERIOD:  sp_cfg_q <= cfg_data_i[10:0];
          ppo_pkg::REG_LONG_PERIOD:   lp_cfg_q <= cfg_data_i[10:0];
          ppo_pkg::REG_SIGNAL_PERIOD: gp_cfg_q <= cfg_data_i[10:0];
          ppo_pkg::REG_DIVIDE_LONG:   dbl_q <= cfg_data_i[0];
          ppo_pkg::REG_SHORT_WEIGHT:  sw_q <= cfg_data_i;
          ppo_pkg::REG_LONG_WEIGHT:   lw_q <= cfg_data_i;
          ppo_pkg::REG_SIGNAL_WEIGHT: gw_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: if (in_valid) begin
          // take the item; clear the series where asked
          price_q <= price_i; ppo_ok_q <= 1'b0; sig_ok_q <= 1'b0;
          ppo_q <= '0; hist_q <= '0;
          if (series_start_i) begin
            seen_q <= '0; cnt_q <= '0; ssum_q <= '0; lsum_q <= '0; psum_q <= '0;
            savg_q <= '0; lavg_q <= '0; gavg_q <= '0; prev_q <= '0;
          end else prev_q <= seen_q;
          state_q <= S_SHORT;
        end
        S_SHORT: begin
          seen_q <= (prev_q < cap) ? prev_q + 11'd1 : prev_q;
          if (prev_q < sp) begin
            if (req.start) begin
              ssum_q <= '0; state_q <= S_SDIV;
            end else begin
              ssum_q <= ssum_q + 42'(price_q); state_q <= S_LONG;
            end
          end else begin
            savg_q <= blend(savg_q, price_q, sw_q); state_q <= S_LONG;
          end
        end
        S_SDIV: if (rsp.done) begin savg_q <= q64[31:0]; state_q <= S_LONG; end
        S_LONG: begin
          if (prev_q < lp) begin
            lsum_q <= req.start ? '0 : lsum_q + 42'(price_q);
            state_q <= req.start ? S_LDIV : S_PPO;
          end else begin
            lavg_q <= blend(lavg_q, price_q, lw_q); state_q <= S_PPO;
          end
        end
        S_LDIV: if (rsp.done) begin lavg_q <= q64[31:0]; state_q <= S_PPO; end
        S_PPO: begin
          neg_q <= savg_q < lavg_q;
          state_q <= req.start ? S_PDIV : S_OUT;
        end
        S_PDIV: if (rsp.done) begin
          ppo_q <= sat(ppo_s); ppo_ok_q <= 1'b1; state_q <= S_SIG;
        end
        S_SIG: begin
          if (cnt_q < gp) begin
            psum_q <= psum_nx;
            cnt_q <= cnt_q + 11'd1;
            if (cnt_q + 11'd1 == gp) begin
              neg_q <= psum_nx[41];
              state_q <= S_GDIV;
            end else state_q <= S_OUT;
          end else begin
            gavg_q <= blend(gavg_q ^ 32'h80000000, ppo_q ^ 32'h80000000, gw_q)
                      ^ 32'h80000000;
            state_q <= S_BLEND;
          end
        end
        S_GDIV: if (rsp.done) begin
          gavg_q <= sat(neg_q ? -43'(q64[41:0]) : 43'(q64[41:0]));
          psum_q <= '0; state_q <= S_BLEND;
        end
        S_BLEND: begin
          sig_ok_q <= 1'b1;
          hist_q <= sat(43'(signed'(ppo_q)) - 43'(signed'(gavg_q)));
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
